[rtl/npr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node presence registry package
// Shared widths, codes and record types for the registry blocks.
// ----------------------------------------------------------------------------
package npr_pkg;

	localparam int NPR_SLOTS_DEF   = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int TIME_W          = 48;
	localparam int BASE_W          = 11;
	localparam int LIMIT_W         = 7;
	localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int IN_DATA_W       = 160;
	localparam int OUT_DATA_W      = 104;

	localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
	localparam logic [1:0] KIND_QUERY    = 2'd1;
	localparam logic [1:0] KIND_LIST     = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INSERT  = 2'd1;
	localparam logic [1:0] ST_DROP    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [7:0]        mtype;
		logic [7:0]        node;
		logic [7:0]        major;
		logic [7:0]        minor;
		logic [7:0]        caps;
		logic [BASE_W-1:0] base;
		logic [TIME_W-1:0] seen;
	} entry_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              present;
		logic [7:0]        mtype;
		logic [7:0]        node;
		logic [7:0]        major;
		logic [7:0]        minor;
		logic [7:0]        caps;
		logic [BASE_W-1:0] base;
		logic [TIME_W-1:0] seen;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_INSERT,
		S_FINISH
	} state_t;

endpackage

[rtl/node_presence_registry_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node presence registry
// Table of bus nodes keyed by node type and node id, with announce, query
// and list operations over a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// The table lives in a ring of TABLE_SLOTS cells that rotates one slot per
// cycle past a single controller, so every item's scan walks the whole table
// once in slot order. A query, an announce that updates an existing entry, a
// dropped announce and a list each take one full rotation of the ring, plus
// accepting the item and handing over the result. An announce that inserts a
// new entry needs a second rotation to reach the free slot. During a list
// the ring pauses whenever an entry is ready but the output item has not
// been taken, so back-pressure on the result side stretches the list
// accordingly. One input item is handled at a time; the next is taken once
// the final result of the current one sits in the output register. The
// valid marks of all slots are cleared by reset directly, so the block is
// ready right after reset.
// ----------------------------------------------------------------------------
module node_presence_registry_top
	import npr_pkg::*;
#(
	parameter int TABLE_SLOTS = NPR_SLOTS_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	// Fields from bit 0: node type, node id, major version, minor version,
	// capabilities, block_base, now_ms, max_age, list_limit, zero fill.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Field: kind.
	input  logic [1:0]            s_axis_tuser,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: present, out_type, out_node, out_major, out_minor,
	// out_caps, out_base, out_seen, zero fill.
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// Field: status.
	output logic [1:0]            m_axis_tuser,
	output logic                  m_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready
);

	entry_t  ring [TABLE_SLOTS];
	entry_t  wb;
	entry_t  in_entry;
	logic    shift;
	result_t res;

	// The announced fields arrive as an entry record; now_ms rides in the
	// seen field so that it can be stamped straight into a slot.
	always_comb begin
		in_entry.valid = 1'b0;
		in_entry.mtype = s_axis_tdata[7:0];
		in_entry.node  = s_axis_tdata[15:8];
		in_entry.major = s_axis_tdata[23:16];
		in_entry.minor = s_axis_tdata[31:24];
		in_entry.caps  = s_axis_tdata[39:32];
		in_entry.base  = s_axis_tdata[50:40];
		in_entry.seen  = s_axis_tdata[98:51];
	end

	// Cell k takes its neighbor k+1 on each shift; the last cell takes the
	// entry that the controller writes back after looking at the head.
	for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
		entry_t d;
		if (k == TABLE_SLOTS - 1) begin : g_tail
			assign d = wb;
		end else begin : g_mid
			assign d = ring[k + 1];
		end
		npr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[k])
		);
	end

	npr_ctrl #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_entry   (in_entry),
		.in_max_age (s_axis_tdata[146:99]),
		.in_limit   (s_axis_tdata[153:147]),
		.head       (ring[0]),
		.wb         (wb),
		.shift      (shift),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res),
		.out_last   (m_axis_tlast)
	);

	// Result item packing.
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {4'b0, res.seen, res.base, res.caps, res.minor, res.major,
	                       res.node, res.mtype, res.present};

endmodule

[rtl/npr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry slot cell
// Holds one table entry and passes it on to its neighbor when the ring shifts.
// ----------------------------------------------------------------------------
module npr_cell
	import npr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	logic   valid_q;
	entry_t data_q;

	// Only the valid mark is cleared; the rest is meaningless until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q       = data_q;
		q.valid = valid_q;
	end

endmodule

[rtl/npr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry controller
// Sequences scan and insert passes over the slot ring and builds the results.
// ----------------------------------------------------------------------------
module npr_ctrl
	import npr_pkg::*;
#(
	parameter int TABLE_SLOTS = NPR_SLOTS_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_kind,
	input  entry_t                in_entry,
	input  logic [TIME_W-1:0]     in_max_age,
	input  logic [LIMIT_W-1:0]    in_limit,
	input  entry_t                head,
	output entry_t                wb,
	output logic                  shift,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_res,
	output logic                  out_last
);

	localparam int CW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        free_idx_q;
	logic                 free_q, match_q, pend_q;
	logic [COUNT_W-1:0]   count_q;
	logic [1:0]           kind_q;
	entry_t               item_q;
	logic [TIME_W-1:0]    max_age_q;
	logic [LIMIT_W-1:0]   limit_q;
	result_t              res_q;
	result_t              out_q;
	logic                 out_valid_q, out_last_q;

	logic    hit, take, emit_mid, out_free, last_step, free_now, present, need_ins, drop;
	result_t none_rec, head_rec, item_rec, drop_rec, qry_rec, ins_rec;

	assign out_free  = !out_valid_q || out_ready;
	assign last_step = (cnt_q == CW'(TABLE_SLOTS - 1));
	assign hit       = head.valid && (head.mtype == item_q.mtype) && (head.node == item_q.node);
	assign take      = (kind_q == KIND_LIST) && head.valid
	                   && (LIMIT_W'(count_q) < limit_q) && (count_q < COUNT_W'(MAX_RESULTS));
	assign free_now  = !head.valid && !free_q;
	assign present   = (max_age_q == '0)
	                   || ((item_q.seen >= head.seen) && ((item_q.seen - head.seen) <= max_age_q));
	assign need_ins  = (kind_q == KIND_ANNOUNCE) && !match_q && !hit;
	assign drop      = need_ins && !free_q && !free_now;

	always_comb begin
		none_rec        = '0;
		none_rec.status = ST_MISSING;
		head_rec        = '{status: ST_OK, present: 1'b0, mtype: head.mtype, node: head.node,
		                    major: head.major, minor: head.minor, caps: head.caps,
		                    base: head.base, seen: head.seen};
		item_rec        = '{status: ST_OK, present: 1'b0, mtype: item_q.mtype,
		                    node: item_q.node, major: item_q.major, minor: item_q.minor,
		                    caps: item_q.caps, base: item_q.base, seen: item_q.seen};
		drop_rec        = '0;
		drop_rec.status = ST_DROP;
		drop_rec.mtype  = item_q.mtype;
		drop_rec.node   = item_q.node;
		qry_rec         = head_rec;
		qry_rec.present = present;
		ins_rec         = item_rec;
		ins_rec.status  = ST_INSERT;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_kind != KIND_NONE) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (shift && last_step) begin
					state_d = (need_ins && !drop) ? S_INSERT : S_FINISH;
				end
			end
			S_INSERT: begin
				if (last_step) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs and write-back into the ring tail.
	always_comb begin
		in_ready = 1'b0;
		shift    = 1'b0;
		emit_mid = 1'b0;
		wb       = head;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_SCAN: begin
				emit_mid = take && pend_q;
				shift    = !(emit_mid && !out_free);
				if (kind_q == KIND_ANNOUNCE && hit) begin
					wb.major = item_q.major;
					wb.minor = item_q.minor;
					wb.caps  = item_q.caps;
					wb.base  = item_q.base;
					wb.seen  = item_q.seen;
				end
			end
			S_INSERT: begin
				shift = 1'b1;
				if (cnt_q == free_idx_q) begin
					wb       = item_q;
					wb.valid = 1'b1;
				end
			end
			S_FINISH: begin
				shift = 1'b0;
			end
			default: shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			free_q      <= 1'b0;
			match_q     <= 1'b0;
			pend_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				cnt_q   <= '0;
				free_q  <= 1'b0;
				match_q <= 1'b0;
				pend_q  <= 1'b0;
				count_q <= '0;
			end else if (shift) begin
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
				if (state_q == S_SCAN) begin
					if (kind_q == KIND_ANNOUNCE && hit) begin
						match_q <= 1'b1;
					end
					if (free_now) begin
						free_q <= 1'b1;
					end
					if (take) begin
						pend_q  <= 1'b1;
						count_q <= count_q + 1'b1;
					end
				end
			end
			if ((emit_mid && out_free) || (state_q == S_FINISH && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, result record and output payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q    <= in_kind;
			item_q    <= in_entry;
			max_age_q <= in_max_age;
			limit_q   <= in_limit;
			res_q     <= none_rec;
		end
		if (state_q == S_SCAN && shift) begin
			if (free_now) begin
				free_idx_q <= cnt_q;
			end
			if (kind_q == KIND_ANNOUNCE && hit) begin
				res_q <= item_rec;
			end else if (kind_q == KIND_QUERY && hit) begin
				res_q <= qry_rec;
			end else if (take) begin
				res_q <= head_rec;
			end else if (last_step && drop) begin
				res_q <= drop_rec;
			end
		end
		if (state_q == S_INSERT && cnt_q == free_idx_q) begin
			res_q <= ins_rec;
		end
		if (emit_mid && out_free) begin
			out_q      <= res_q;
			out_last_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_q      <= res_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	// The ring is back in slot order whenever a new item can be taken.
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> cnt_q == '0)
		else $error("slot ring not realigned in idle");

	// A list entry waiting on a full output holds the ring in place.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_mid && !out_free) |=> $stable(cnt_q))
		else $error("ring moved while a list entry was stalled");

	// An insert pass only follows an announce that found a free slot and no match.
	a_insert_cause: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INSERT |-> (free_q && !match_q && kind_q == KIND_ANNOUNCE))
		else $error("insert pass without a free slot");

	// A list never takes more entries than the cap.
	a_list_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_RESULTS))
		else $error("list count above cap");
`endif

endmodule
